### rtl/lse_pkg.sv
package lse_pkg;

    localparam int BYTE_BITS = 8;
    localparam int HIDDEN_BIT = 0;
    localparam logic [7:0] HEADER_SKIP_RESET = 8'd54;

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_MAGIC  = 3'd1;
    localparam logic [2:0] PH_EXTLEN = 3'd2;
    localparam logic [2:0] PH_EXT    = 3'd3;
    localparam logic [2:0] PH_SIZE   = 3'd4;
    localparam logic [2:0] PH_DATA   = 3'd5;
    localparam logic [2:0] PH_DONE   = 3'd6;

    localparam logic [1:0] KIND_MAGIC = 2'd0;
    localparam logic [1:0] KIND_EXT   = 2'd1;
    localparam logic [1:0] KIND_DATA  = 2'd2;

    typedef struct packed {
        logic [7:0] out_byte;
        logic [1:0] byte_kind;
        logic       last;
    } result_t;

endpackage

### rtl/lse_pixel_if.sv
interface lse_pixel_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       start_of_image;

    modport source (output valid, output pixel_byte, output start_of_image, input ready);
    modport sink (input valid, input pixel_byte, input start_of_image, output ready);
endinterface

### rtl/lse_result_if.sv
interface lse_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [1:0] byte_kind;
    logic       last;

    modport source (output valid, output out_byte, output byte_kind, output last, input ready);
    modport sink (input valid, input out_byte, input byte_kind, input last, output ready);
endinterface

### rtl/lsb_stego_stream_extractor.sv
// Recovers a record hidden in bit 0 of the bytes of an image stream.
// Channel pixels (sink) takes one image byte per transfer; start_of_image on
// a byte restarts the parse with that byte as header byte zero. After
// header_skip bytes the hidden bits form a magic byte, an extension length,
// the extension characters, a payload size and the payload bytes.
// Channel hidden (source) gives the magic byte, every extension character and
// every payload byte, tagged by byte_kind, with last on the final one of a run.
// header_skip is written through cfg_we / cfg_wdata by the user only while the
// block is idle; the block itself does not enforce this. Throughput is one
// byte per cycle while the skid entry is free: the parse state is updated
// combinationally from the input register, with no loop over clocks.
// A result is registered in the input register, then in the output register or skid.
// The output register is backed by one skid entry; a stalled receiver fills
// the skid, and only then does pixels.ready drop, so no byte is lost.
// Reset restores header_skip to 54, empties both stages and starts in the
// header skip phase as though a start of image had been seen.
module lsb_stego_stream_extractor
    import lse_pkg::*;
#(
    parameter int LENGTH_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    lse_pixel_if.sink           pixels,
    lse_result_if.source        hidden
);

    localparam int CNT_W = $clog2(LENGTH_BITS);
    localparam logic [CNT_W:0] BYTE_CNT = (CNT_W + 1)'(BYTE_BITS);
    localparam logic [CNT_W:0] LEN_CNT  = (CNT_W + 1)'(LENGTH_BITS);

    logic [7:0]             header_skip_reg;

    logic                   in_valid_reg;
    logic                   in_bit_reg;
    logic                   in_sof_reg;

    logic [2:0]             phase_reg, phase_next;
    logic [7:0]             header_count_reg, header_count_next;
    logic [CNT_W-1:0]       bit_count_reg, bit_count_next;
    logic [LENGTH_BITS-1:0] gather_reg, gather_next;
    logic [LENGTH_BITS-1:0] remaining_reg, remaining_next;

    result_t                out_reg, skid_reg, res;
    logic                   out_valid_reg, skid_valid_reg;
    logic                   res_en;

    logic                   advance;
    logic                   out_take;
    logic                   skipped;
    logic [CNT_W:0]         bc_sum;
    logic [LENGTH_BITS-1:0] shifted;
    logic [LENGTH_BITS-1:0] rem_dec;

    // The parse stage moves on whenever the skid entry is free to catch a result.
    assign advance      = in_valid_reg && !skid_valid_reg;
    assign pixels.ready = !in_valid_reg || !skid_valid_reg;
    assign out_take     = out_valid_reg && hidden.ready;

    assign hidden.valid     = out_valid_reg;
    assign hidden.out_byte  = out_reg.out_byte;
    assign hidden.byte_kind = out_reg.byte_kind;
    assign hidden.last      = out_reg.last;

    always_comb
    begin
        phase_next        = phase_reg;
        header_count_next = header_count_reg;
        bit_count_next    = bit_count_reg;
        gather_next       = gather_reg;
        remaining_next    = remaining_reg;
        res_en            = 1'b0;
        res               = '0;
        skipped           = 1'b0;
        bc_sum            = '0;
        shifted           = '0;
        rem_dec           = '0;

        if (in_sof_reg)
        begin
            phase_next        = PH_HEADER;
            header_count_next = '0;
            bit_count_next    = '0;
            gather_next       = '0;
            remaining_next    = '0;
        end

        if (phase_next == PH_HEADER)
        begin
            if (header_count_next < header_skip_reg)
            begin
                header_count_next = header_count_next + 8'd1;
                skipped           = 1'b1;
            end
            else
            begin
                phase_next     = PH_MAGIC;
                bit_count_next = '0;
                gather_next    = '0;
            end
        end

        if (!skipped)
        begin
            bc_sum  = {1'b0, bit_count_next} + (CNT_W + 1)'(1);
            shifted = {gather_next[LENGTH_BITS-2:0], in_bit_reg};
            rem_dec = remaining_next - LENGTH_BITS'(1);
            unique case (phase_next)
                PH_MAGIC:
                begin
                    gather_next = shifted;
                    if (bc_sum >= BYTE_CNT)
                    begin
                        bit_count_next = '0;
                        gather_next    = '0;
                        phase_next     = PH_EXTLEN;
                        res_en         = 1'b1;
                        res.out_byte   = shifted[7:0];
                        res.byte_kind  = KIND_MAGIC;
                        res.last       = 1'b1;
                    end
                    else
                        bit_count_next = bc_sum[CNT_W-1:0];
                end
                PH_EXTLEN:
                begin
                    gather_next = shifted;
                    if (bc_sum >= LEN_CNT)
                    begin
                        bit_count_next = '0;
                        gather_next    = '0;
                        remaining_next = shifted;
                        phase_next     = (shifted == '0) ? PH_SIZE : PH_EXT;
                    end
                    else
                        bit_count_next = bc_sum[CNT_W-1:0];
                end
                PH_EXT, PH_DATA:
                begin
                    gather_next = shifted;
                    if (bc_sum >= BYTE_CNT)
                    begin
                        bit_count_next = '0;
                        gather_next    = '0;
                        remaining_next = rem_dec;
                        if (rem_dec == '0)
                            phase_next = (phase_next == PH_EXT) ? PH_SIZE : PH_DONE;
                        res_en        = 1'b1;
                        res.out_byte  = shifted[7:0];
                        res.byte_kind = (phase_reg == PH_DATA && !in_sof_reg) ? KIND_DATA
                                        : ((phase_next == PH_DONE) ? KIND_DATA : KIND_EXT);
                        res.last      = (rem_dec == '0);
                    end
                    else
                        bit_count_next = bc_sum[CNT_W-1:0];
                end
                PH_SIZE:
                begin
                    gather_next = shifted;
                    if (bc_sum >= LEN_CNT)
                    begin
                        bit_count_next = '0;
                        gather_next    = '0;
                        // A size with its top bit set counts as negative: no payload.
                        if (shifted[LENGTH_BITS-1] || shifted == '0)
                        begin
                            remaining_next = '0;
                            phase_next     = PH_DONE;
                        end
                        else
                        begin
                            remaining_next = shifted;
                            phase_next     = PH_DATA;
                        end
                    end
                    else
                        bit_count_next = bc_sum[CNT_W-1:0];
                end
                default:
                    phase_next = PH_DONE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_skip_reg  <= HEADER_SKIP_RESET;
            in_valid_reg     <= 1'b0;
            phase_reg        <= PH_HEADER;
            header_count_reg <= '0;
            bit_count_reg    <= '0;
            gather_reg       <= '0;
            remaining_reg    <= '0;
            out_valid_reg    <= 1'b0;
            skid_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                header_skip_reg <= cfg_wdata;

            if (pixels.ready)
                in_valid_reg <= pixels.valid;

            if (advance)
            begin
                phase_reg        <= phase_next;
                header_count_reg <= header_count_next;
                bit_count_reg    <= bit_count_next;
                gather_reg       <= gather_next;
                remaining_reg    <= remaining_next;
            end

            if (!out_valid_reg || out_take)
            begin
                out_valid_reg  <= skid_valid_reg || (advance && res_en);
                skid_valid_reg <= 1'b0;
            end
            else if (advance && res_en)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pixels.ready)
        begin
            in_bit_reg <= pixels.pixel_byte[HIDDEN_BIT];
            in_sof_reg <= pixels.start_of_image;
        end

        if (!out_valid_reg || out_take)
            out_reg <= skid_valid_reg ? skid_reg : res;
        else if (advance && res_en)
            skid_reg <= res;
    end

endmodule

### rtl/lse_checker.sv
module lse_checker
    import lse_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic [1:0] byte_kind,
    input logic       last
);

    // A held result keeps its value until the transfer completes.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(byte_kind) && $stable(last))
        else $error("result changed or dropped while stalled");

    a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (byte_kind == KIND_MAGIC || byte_kind == KIND_EXT
            || byte_kind == KIND_DATA))
        else $error("byte_kind outside the defined codes");

    a_magic_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_kind == KIND_MAGIC |-> last)
        else $error("magic byte without last");

    // Input backpressure only comes from a full output side.
    a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid)
        else $error("input stalled with an empty output register");

endmodule

bind lsb_stego_stream_extractor lse_checker u_lse_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (pixels.ready),
    .out_valid (hidden.valid),
    .out_ready (hidden.ready),
    .out_byte  (hidden.out_byte),
    .byte_kind (hidden.byte_kind),
    .last      (hidden.last)
);

### tb/sv/tb_lsb_stego_stream_extractor.sv
`timescale 1ns / 100ps

module tb_lsb_stego_stream_extractor;
    import lse_pkg::*;

    localparam int LEN_BITS = 32;
    localparam logic [31:0] LEN_MASK = 32'hFFFF_FFFF >> (32 - LEN_BITS);

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [7:0] cfg_wdata;

    lse_pixel_if pix ();
    lse_result_if res ();

    lsb_stego_stream_extractor #(
        .LENGTH_BITS (LEN_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .pixels    (pix),
        .hidden    (res)
    );

    // Shadow of the parser state and of the header_skip register.
    logic [7:0]  hdr_skip_reg = HEADER_SKIP_RESET;
    logic [2:0]  parse_phase = PH_HEADER;
    logic [7:0]  hdr_seen = '0;
    logic [4:0]  bits_in_field = '0;
    logic [31:0] field_shift = '0;
    logic [31:0] bytes_left = '0;

    result_t hidden_expected[$];
    logic [7:0] image_bytes[$];

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int sink_hold_left = 0;
    int pixels_sent = 0;
    int hidden_predicted = 0;
    int hidden_checked = 0;
    int error_count = 0;
    int kind_seen[0:2] = '{0, 0, 0};

    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    function automatic void queue_hidden(input logic [7:0] val, input logic [1:0] kind,
                                         input logic is_last);
        result_t r;
        r.out_byte = val;
        r.byte_kind = kind;
        r.last = is_last;
        hidden_expected.push_back(r);
        hidden_predicted++;
    endfunction

    function automatic logic shift_in_bit(input logic b, input int width);
        field_shift = {field_shift[30:0], b};
        if (int'(bits_in_field) + 1 >= width)
        begin
            bits_in_field = '0;
            return 1'b1;
        end
        bits_in_field = bits_in_field + 5'd1;
        return 1'b0;
    endfunction

    // Advances the shadow parser by one accepted image byte.
    function automatic void recover_hidden(input logic [7:0] pb, input logic sof);
        logic b;
        logic [31:0] v;
        b = pb[HIDDEN_BIT];
        if (sof)
        begin
            parse_phase = PH_HEADER;
            hdr_seen = '0;
            bits_in_field = '0;
            field_shift = '0;
            bytes_left = '0;
        end
        if (parse_phase == PH_HEADER)
        begin
            if (hdr_seen < hdr_skip_reg)
            begin
                hdr_seen = hdr_seen + 8'd1;
                return;
            end
            parse_phase = PH_MAGIC;
            bits_in_field = '0;
            field_shift = '0;
        end
        case (parse_phase)
            PH_MAGIC:
                if (shift_in_bit(b, BYTE_BITS))
                begin
                    v = field_shift;
                    field_shift = '0;
                    parse_phase = PH_EXTLEN;
                    queue_hidden(v[7:0], KIND_MAGIC, 1'b1);
                end
            PH_EXTLEN:
                if (shift_in_bit(b, LEN_BITS))
                begin
                    bytes_left = field_shift & LEN_MASK;
                    field_shift = '0;
                    parse_phase = (bytes_left == 0) ? PH_SIZE : PH_EXT;
                end
            PH_EXT:
                if (shift_in_bit(b, BYTE_BITS))
                begin
                    v = field_shift;
                    field_shift = '0;
                    bytes_left = bytes_left - 32'd1;
                    if (bytes_left == 0)
                        parse_phase = PH_SIZE;
                    queue_hidden(v[7:0], KIND_EXT, bytes_left == 0);
                end
            PH_SIZE:
                if (shift_in_bit(b, LEN_BITS))
                begin
                    v = field_shift & LEN_MASK;
                    field_shift = '0;
                    // A size with its sign bit set counts as negative: no payload.
                    if (v[LEN_BITS-1] || v == 0)
                    begin
                        bytes_left = '0;
                        parse_phase = PH_DONE;
                    end
                    else
                    begin
                        bytes_left = v;
                        parse_phase = PH_DATA;
                    end
                end
            PH_DATA:
                if (shift_in_bit(b, BYTE_BITS))
                begin
                    v = field_shift;
                    field_shift = '0;
                    bytes_left = bytes_left - 32'd1;
                    if (bytes_left == 0)
                        parse_phase = PH_DONE;
                    queue_hidden(v[7:0], KIND_DATA, bytes_left == 0);
                end
            default:
                parse_phase = PH_DONE;
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer.
    task automatic send_pixel(input logic [7:0] pb, input logic sof);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix.valid = 1'b0;
            @(negedge clk);
        end
        pix.valid = 1'b1;
        pix.pixel_byte = pb;
        pix.start_of_image = sof;
        @(posedge clk);
        while (!pix.ready)
            @(posedge clk);
        recover_hidden(pb, sof);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        pix.valid = 1'b0;
        while (hidden_expected.size() != 0)
            @(negedge clk);
        // Bytes that carry no result may still be in the pipeline.
        repeat (6)
            @(negedge clk);
    endtask

    task automatic write_header_skip(input logic [7:0] val);
        wait_drained();
        cfg_we = 1'b1;
        cfg_wdata = val;
        @(posedge clk);
        hdr_skip_reg = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic void push_noise(input int n);
        repeat (n)
            image_bytes.push_back(8'($urandom));
    endfunction

    function automatic void push_field(input logic [31:0] val, input int width);
        for (int i = width - 1; i >= 0; i--)
            image_bytes.push_back({7'($urandom), val[i]});
    endfunction

    function automatic void build_record(input int hdr, input logic [7:0] magic, input int ext_n,
                                         input logic [31:0] size, input int data_n,
                                         input int tail);
        push_noise(hdr);
        push_field(magic, BYTE_BITS);
        push_field(ext_n, LEN_BITS);
        repeat (ext_n)
            push_field(8'($urandom), BYTE_BITS);
        push_field(size, LEN_BITS);
        repeat (data_n)
            push_field(8'($urandom), BYTE_BITS);
        push_noise(tail);
    endfunction

    task automatic send_image(input logic with_sof, input int keep);
        int n;
        n = (keep < image_bytes.size()) ? keep : image_bytes.size();
        for (int i = 0; i < n; i++)
            send_pixel(image_bytes[i], with_sof && i == 0);
        image_bytes.delete();
    endtask

    task automatic test_start_never_given();
        src_idle_pct = 36;
        snk_idle_pct = 56;
        push_noise(HEADER_SKIP_RESET);
        push_field(8'hA5, BYTE_BITS);
        push_field(1, LEN_BITS);
        push_field(8'hFF, BYTE_BITS);
        push_field(2, LEN_BITS);
        push_field(8'h00, BYTE_BITS);
        push_field(8'h5A, BYTE_BITS);
        push_noise(3);
        send_image(1'b0, image_bytes.size());
    endtask

    task automatic test_zero_header();
        write_header_skip(8'd0);
        // Empty extension, one payload byte.
        push_field(8'h00, BYTE_BITS);
        push_field(0, LEN_BITS);
        push_field(1, LEN_BITS);
        push_field(8'hFF, BYTE_BITS);
        send_image(1'b1, image_bytes.size());
    endtask

    task automatic test_size_sign();
        int hdr;
        hdr = $urandom_range(1, 3);
        write_header_skip(8'(hdr));
        build_record(hdr, 8'($urandom), 0, 32'h8000_0000, 1, 0);
        send_image(1'b1, image_bytes.size());
    endtask

    task automatic test_restart_mid_record();
        int hdr;
        hdr = hdr_skip_reg;
        // Cut inside the extension length; the next start drops the partial field.
        build_record(hdr, 8'($urandom), 1, 2, 2, 0);
        send_image(1'b1, hdr + 20);
        // A zero size ends the record right after the magic byte.
        build_record(hdr, 8'($urandom), 0, 32'h0000_0000, 0, 0);
        send_image(1'b1, image_bytes.size());
    endtask

    task automatic test_skip_changed_mid_header();
        write_header_skip(8'd54);
        push_noise(12);
        send_image(1'b1, 12);
        // The count is already past the new limit, so the magic starts at once.
        write_header_skip(8'd10);
        build_record(0, 8'($urandom), 0, 1, 1, 0);
        send_image(1'b0, image_bytes.size());
        write_header_skip(8'd5);
        push_noise(3);
        send_image(1'b1, 3);
        write_header_skip(8'd8);
        build_record(5, 8'($urandom), 0, 1, 1, 0);
        send_image(1'b0, image_bytes.size());
    endtask

    task automatic test_output_stall();
        write_header_skip(8'd1);
        build_record(1, 8'h3C, 0, 8, 8, 2);
        // The receiver holds off while the sender keeps offering bytes.
        sink_hold_left = 300;
        send_image(1'b1, image_bytes.size());
    endtask

    task automatic random_record();
        int pick;
        int hdr;
        int size;
        logic [31:0] bad_size;
        pick = $urandom_range(99);
        hdr = hdr_skip_reg;
        size = $urandom_range(1, 4);
        if (pick < 70)
        begin
            build_record(hdr, 8'($urandom), $urandom_range(0, 3), size, size,
                         $urandom_range(0, 3));
            send_image(1'b1, image_bytes.size());
        end
        else if (pick < 78)
        begin
            build_record(hdr, 8'($urandom), $urandom_range(0, 3), size, size, 0);
            send_image(1'b1, $urandom_range(1, image_bytes.size()));
        end
        else if (pick < 84)
        begin
            bad_size = $urandom_range(0, 1) ? {1'b1, 31'($urandom)} : 32'd0;
            build_record(hdr, 8'($urandom), $urandom_range(0, 2), bad_size,
                         $urandom_range(0, 4), 0);
            send_image(1'b1, image_bytes.size());
        end
        else if (pick < 90)
        begin
            build_record($urandom_range(0, hdr + 3), 8'($urandom), $urandom_range(0, 2), size,
                         size, 0);
            send_image(1'b1, image_bytes.size());
        end
        else if (pick < 95)
        begin
            push_noise(hdr);
            push_field(8'($urandom), BYTE_BITS);
            push_field($urandom, LEN_BITS);
            push_noise($urandom_range(8, 24));
            send_image(1'b1, image_bytes.size());
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                send_pixel(8'($urandom), $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic test_random_traffic(input int src_pct, input int snk_pct,
                                       input logic [7:0] skip, input int item_goal);
        int first_item;
        int first_result;
        write_header_skip(skip);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        first_item = pixels_sent;
        first_result = hidden_predicted;
        while (pixels_sent - first_item < item_goal || hidden_predicted - first_result < 2)
            random_record();
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_left > 0)
            begin
                res.ready = 1'b0;
                sink_hold_left--;
            end
            else
                res.ready = ($urandom_range(99) >= snk_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && res.valid && res.ready)
        begin
            hidden_checked++;
            if (res.byte_kind <= KIND_DATA)
                kind_seen[res.byte_kind]++;
            if (hidden_expected.size() == 0)
            begin
                error_count++;
                $display("%0t: unexpected transfer: byte %02h kind %0d last %0b", $time,
                         res.out_byte, res.byte_kind, res.last);
            end
            else
            begin
                want = hidden_expected.pop_front();
                if (res.out_byte !== want.out_byte)
                begin
                    error_count++;
                    $display("%0t: out_byte expected %02h actual %02h", $time,
                             want.out_byte, res.out_byte);
                end
                if (res.byte_kind !== want.byte_kind)
                begin
                    error_count++;
                    $display("%0t: byte_kind expected %0d actual %0d", $time,
                             want.byte_kind, res.byte_kind);
                end
                if (res.last !== want.last)
                begin
                    error_count++;
                    $display("%0t: last expected %0b actual %0b", $time, want.last, res.last);
                end
            end
        end
    end

    initial
    begin
        #5000000;
        $display("CHECKS FAILED");
        $display("Timed out with %0d results still expected.", hidden_expected.size());
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        pix.valid = 1'b0;
        pix.pixel_byte = '0;
        pix.start_of_image = 1'b0;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_start_never_given();
        test_zero_header();
        test_size_sign();
        test_restart_mid_record();
        test_skip_changed_mid_header();
        test_output_stall();
        test_random_traffic(36, 56, 8'($urandom_range(0, 7)), 60);
        test_random_traffic(56, 36, 8'($urandom_range(1, 16)), 60);
        test_random_traffic(0, 0, 8'($urandom_range(0, 4)), 60);

        wait_drained();
        repeat (10)
            @(negedge clk);
        if (hidden_expected.size() != 0)
            error_count++;
        $display("Sent %0d image bytes; checked %0d hidden bytes (%0d magic, %0d ext, %0d data).",
                 pixels_sent, hidden_checked, kind_seen[0], kind_seen[1], kind_seen[2]);
        $display("Default, zero and changed header skips, restarts, empty extensions, %s",
                 "negative and zero sizes, and a long output stall.");
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

### lsb_stego_stream_extractor.f
rtl/lse_pkg.sv
rtl/lse_pixel_if.sv
rtl/lse_result_if.sv
rtl/lsb_stego_stream_extractor.sv
rtl/lse_checker.sv
tb/sv/tb_lsb_stego_stream_extractor.sv
